// File: design/kcv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcv_pkg: shared types, constants and helpers for the constant-velocity
// tracker. Holds the sequencer states, the command group from controller to
// datapath, and the signed 32-bit saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package kcv_pkg;

    localparam int DATA_W        = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int DEF_FRAC_BITS = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_Q_POS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Q_VEL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_R_MEAS = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRED,
        ST_DINIT,
        ST_DIV,
        ST_GAIN,
        ST_MUL,
        ST_ACC,
        ST_OUT
    } state_t;

    // One multiply-and-correct operation of the update phase.
    typedef enum logic [2:0] {
        MOP_POS,
        MOP_VEL,
        MOP_PP,
        MOP_PV,
        MOP_VV
    } mop_t;

    typedef struct packed {
        logic load_meas;
        logic predict;
        logic div_init;
        logic div_step;
        logic gain;
        logic mul_en;
        logic acc_en;
        logic out_load;
        mop_t op;
    } cmd_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] max_v;
        logic signed [63:0] min_v;
        max_v = 64'sh0000_0000_7FFF_FFFF;
        min_v = -64'sh0000_0000_8000_0000;
        if (v > max_v) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < min_v) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[DATA_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// File: design/kcv_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcv_datapath: state, configuration and arithmetic of the tracker.
// Prediction adders, a two-lane restoring divider for the gains, one shared
// signed multiplier and the saturating correction adder.
// ----------------------------------------------------------------------------
`default_nettype none

module kcv_datapath #(
    parameter int FRAC_BITS = kcv_pkg::DEF_FRAC_BITS
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_we,
    input  wire [kcv_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire [kcv_pkg::DATA_W-1:0]            cfg_data,
    input  kcv_pkg::cmd_t                        cmd,
    input  wire signed [kcv_pkg::DATA_W-1:0]     measurement,
    output logic signed [kcv_pkg::DATA_W-1:0]    filtered_pos
);

    localparam int NUM_W = kcv_pkg::DATA_W + FRAC_BITS;
    localparam logic [kcv_pkg::DATA_W-1:0] ONE_FX = kcv_pkg::DATA_W'(64'd1 << FRAC_BITS);
    localparam logic [kcv_pkg::DATA_W-1:0] Q_RST  =
        kcv_pkg::DATA_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [kcv_pkg::DATA_W-1:0] R_RST  =
        kcv_pkg::DATA_W'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [NUM_W-1:0] HALF_RANGE = NUM_W'(64'h8000_0000);
    localparam logic [NUM_W-1:0] POS_MAX    = NUM_W'(64'h7FFF_FFFF);

    logic [31:0] q_pos_reg, q_vel_reg, r_meas_reg;
    logic signed [31:0] est_pos_reg, est_vel_reg, cov_pp_reg, cov_pv_reg, cov_vv_reg;
    logic signed [31:0] meas_reg, pos_p_reg, ppp_reg, ppv_reg, pvv_reg, innov_reg;
    logic signed [31:0] k0_reg, k1_reg, out_reg;
    logic [33:0] s_reg;
    logic s_pos_reg, neg0_reg, neg1_reg;
    logic [33:0] rem0_reg, rem1_reg;
    logic [NUM_W-1:0] d0_reg, d1_reg;
    logic signed [63:0] prod_reg;
    kcv_pkg::mop_t acc_op_reg;

    // Prediction.
    logic signed [31:0] pos_p_next, ppp_next, ppv_next, pvv_next;
    always_comb
    begin
        pos_p_next = kcv_pkg::sat32(64'(est_pos_reg) + 64'(est_vel_reg));
        ppp_next = kcv_pkg::sat32(64'(cov_pp_reg) + (64'(cov_pv_reg) <<< 1)
                                  + 64'(cov_vv_reg) + $signed({32'd0, q_pos_reg}));
        ppv_next = kcv_pkg::sat32(64'(cov_pv_reg) + 64'(cov_vv_reg));
        pvv_next = kcv_pkg::sat32(64'(cov_vv_reg) + $signed({32'd0, q_vel_reg}));
    end

    // Divider setup.
    logic signed [33:0] s_next;
    logic [32:0] mag0, mag1;
    always_comb
    begin
        s_next = 34'(ppp_reg) + $signed({2'b00, r_meas_reg});
        mag0 = ppp_reg[31] ? 33'(-34'(ppp_reg)) : 33'(ppp_reg);
        mag1 = ppv_reg[31] ? 33'(-34'(ppv_reg)) : 33'(ppv_reg);
    end

    // One restoring step per lane.
    logic [34:0] rsh0, rsh1;
    logic ge0, ge1;
    always_comb
    begin
        rsh0 = {rem0_reg, d0_reg[NUM_W-1]};
        rsh1 = {rem1_reg, d1_reg[NUM_W-1]};
        ge0 = rsh0 >= {1'b0, s_reg};
        ge1 = rsh1 >= {1'b0, s_reg};
    end

    function automatic logic signed [31:0] gain_of(input logic [NUM_W-1:0] q, input logic neg);
        if (neg) begin
            gain_of = (q > HALF_RANGE) ? 32'sh8000_0000 : -$signed(q[31:0]);
        end else begin
            gain_of = (q > POS_MAX) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
        end
    endfunction

    // Shared multiplier operands.
    logic signed [31:0] op_a, op_b;
    always_comb
    begin
        unique case (cmd.op)
            kcv_pkg::MOP_POS: begin op_a = k0_reg; op_b = innov_reg; end
            kcv_pkg::MOP_VEL: begin op_a = k1_reg; op_b = innov_reg; end
            kcv_pkg::MOP_PP:  begin op_a = k0_reg; op_b = ppp_reg;   end
            kcv_pkg::MOP_PV:  begin op_a = k0_reg; op_b = ppv_reg;   end
            kcv_pkg::MOP_VV:  begin op_a = k1_reg; op_b = ppv_reg;   end
            default:          begin op_a = k1_reg; op_b = ppv_reg;   end
        endcase
    end

    // Scaled product, floored, then the correction.
    logic signed [31:0] fx;
    logic signed [63:0] fx_w;
    always_comb
    begin
        fx = kcv_pkg::sat32(prod_reg >>> FRAC_BITS);
        fx_w = 64'(fx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            q_pos_reg   <= Q_RST;
            q_vel_reg   <= Q_RST;
            r_meas_reg  <= R_RST;
            est_pos_reg <= '0;
            est_vel_reg <= '0;
            cov_pp_reg  <= ONE_FX;
            cov_pv_reg  <= '0;
            cov_vv_reg  <= ONE_FX;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    kcv_pkg::REG_Q_POS:  q_pos_reg  <= cfg_data;
                    kcv_pkg::REG_Q_VEL:  q_vel_reg  <= cfg_data;
                    kcv_pkg::REG_R_MEAS: r_meas_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.acc_en) begin
                unique case (acc_op_reg)
                    kcv_pkg::MOP_POS: est_pos_reg <= kcv_pkg::sat32(64'(pos_p_reg) + fx_w);
                    kcv_pkg::MOP_VEL: est_vel_reg <= kcv_pkg::sat32(64'(est_vel_reg) + fx_w);
                    kcv_pkg::MOP_PP:  cov_pp_reg  <= kcv_pkg::sat32(64'(ppp_reg) - fx_w);
                    kcv_pkg::MOP_PV:  cov_pv_reg  <= kcv_pkg::sat32(64'(ppv_reg) - fx_w);
                    kcv_pkg::MOP_VV:  cov_vv_reg  <= kcv_pkg::sat32(64'(pvv_reg) - fx_w);
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_meas) begin
            meas_reg <= measurement;
        end
        if (cmd.predict) begin
            pos_p_reg <= pos_p_next;
            ppp_reg   <= ppp_next;
            ppv_reg   <= ppv_next;
            pvv_reg   <= pvv_next;
        end
        if (cmd.div_init) begin
            innov_reg <= kcv_pkg::sat32(64'(meas_reg) - 64'(pos_p_reg));
            s_reg     <= s_next;
            s_pos_reg <= !s_next[33] && (s_next != '0);
            neg0_reg  <= ppp_reg[31];
            neg1_reg  <= ppv_reg[31];
            rem0_reg  <= '0;
            rem1_reg  <= '0;
            d0_reg    <= {mag0[31:0], {FRAC_BITS{1'b0}}};
            d1_reg    <= {mag1[31:0], {FRAC_BITS{1'b0}}};
        end
        if (cmd.div_step) begin
            rem0_reg <= ge0 ? 34'(rsh0 - {1'b0, s_reg}) : rsh0[33:0];
            rem1_reg <= ge1 ? 34'(rsh1 - {1'b0, s_reg}) : rsh1[33:0];
            d0_reg   <= {d0_reg[NUM_W-2:0], ge0};
            d1_reg   <= {d1_reg[NUM_W-2:0], ge1};
        end
        if (cmd.gain) begin
            k0_reg <= s_pos_reg ? gain_of(d0_reg, neg0_reg) : '0;
            k1_reg <= s_pos_reg ? gain_of(d1_reg, neg1_reg) : '0;
        end
        if (cmd.mul_en) begin
            prod_reg   <= 64'(op_a) * 64'(op_b);
            acc_op_reg <= cmd.op;
        end
        if (cmd.out_load) begin
            out_reg <= est_pos_reg;
        end
    end

    assign filtered_pos = out_reg;

endmodule

`default_nettype wire

// File: design/kcv_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcv_ctrl: sequencer of the tracker.
// Steps one request through predict, gain division, five multiply-correct
// operations and the output register, and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module kcv_ctrl #(
    parameter int FRAC_BITS = kcv_pkg::DEF_FRAC_BITS
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  wire            out_stall,
    output kcv_pkg::cmd_t  cmd
);

    localparam int DIV_STEPS = kcv_pkg::DATA_W + FRAC_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    kcv_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    kcv_pkg::mop_t op_reg, op_next;
    logic out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        op_next    = op_reg;
        unique case (state_reg)
            kcv_pkg::ST_IDLE:  if (in_valid) state_next = kcv_pkg::ST_PRED;
            kcv_pkg::ST_PRED:  state_next = kcv_pkg::ST_DINIT;
            kcv_pkg::ST_DINIT:
            begin
                state_next = kcv_pkg::ST_DIV;
                cnt_next   = '0;
            end
            kcv_pkg::ST_DIV:
            begin
                if (cnt_reg == CNT_LAST) begin
                    state_next = kcv_pkg::ST_GAIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            kcv_pkg::ST_GAIN:
            begin
                state_next = kcv_pkg::ST_MUL;
                op_next    = kcv_pkg::MOP_POS;
            end
            kcv_pkg::ST_MUL:   state_next = kcv_pkg::ST_ACC;
            kcv_pkg::ST_ACC:
            begin
                if (op_reg == kcv_pkg::MOP_VV) begin
                    state_next = kcv_pkg::ST_OUT;
                end else begin
                    state_next = kcv_pkg::ST_MUL;
                    op_next    = kcv_pkg::mop_t'(op_reg + 3'd1);
                end
            end
            kcv_pkg::ST_OUT:
                if (!out_valid_reg || !out_stall) state_next = kcv_pkg::ST_IDLE;
            default: state_next = kcv_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.op        = op_reg;
        cmd.load_meas = (state_reg == kcv_pkg::ST_IDLE) && in_valid;
        cmd.predict   = (state_reg == kcv_pkg::ST_PRED);
        cmd.div_init  = (state_reg == kcv_pkg::ST_DINIT);
        cmd.div_step  = (state_reg == kcv_pkg::ST_DIV);
        cmd.gain      = (state_reg == kcv_pkg::ST_GAIN);
        cmd.mul_en    = (state_reg == kcv_pkg::ST_MUL);
        cmd.acc_en    = (state_reg == kcv_pkg::ST_ACC);
        cmd.out_load  = (state_reg == kcv_pkg::ST_OUT) && (!out_valid_reg || !out_stall);
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else begin
            out_valid_next = out_valid_reg && out_stall;
        end
        in_stall  = (state_reg != kcv_pkg::ST_IDLE);
        out_valid = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= kcv_pkg::ST_IDLE;
            cnt_reg       <= '0;
            op_reg        <= kcv_pkg::MOP_POS;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && out_stall))
        else $error("output register overwritten while a request waits");

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == kcv_pkg::ST_OUT)
        else $error("result raised outside the output step");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == kcv_pkg::ST_GAIN |-> $past(cnt_reg) == CNT_LAST)
        else $error("gain taken before the division finished");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.predict, cmd.div_init, cmd.div_step, cmd.gain,
                  cmd.mul_en, cmd.acc_en}))
        else $error("datapath given more than one command");
`endif

endmodule

`default_nettype wire

// File: design/kalman_cv_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_cv_tracker: two-state constant-velocity Kalman filter
// Predicts position and velocity, divides for the gain, corrects the state
// and covariance, and returns the filtered position in signed fixed point.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                         Direction
//   -------   -----------------------------   ---------
//   input     in_valid, in_stall, measurement  request in
//   output    out_valid, out_stall, filtered_pos  request out
//   config    cfg_we, cfg_index, cfg_data      register write
//
// A request passes from acceptance to the output register through a
// predict step, a divider setup step, the bit-serial gain divider that
// retires one quotient bit per cycle, a gain step, five shared multiplies
// each followed by its correction, and the output step. The next request
// is taken in the idle state that follows, so a new request is never taken
// before the last one is through. The finished result waits in the output
// register, so a stall downstream only delays the next request at its final
// step. Reset loads the default noise registers, zero state and unit
// variances.
// ----------------------------------------------------------------------------
`default_nettype none

module kalman_cv_tracker #(
    parameter int FRAC_BITS = kcv_pkg::DEF_FRAC_BITS
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_we,
    input  wire [kcv_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire [kcv_pkg::DATA_W-1:0]           cfg_data,
    input  wire                                 in_valid,
    output logic                                in_stall,
    input  wire signed [kcv_pkg::DATA_W-1:0]    measurement,
    output logic                                out_valid,
    input  wire                                 out_stall,
    output logic signed [kcv_pkg::DATA_W-1:0]   filtered_pos
);

    // Commands from the sequencer into the arithmetic.
    kcv_pkg::cmd_t cmd;

    kcv_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    kcv_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .measurement  (measurement),
        .filtered_pos (filtered_pos)
    );

endmodule

`default_nettype wire
